FILE: rtl/core/eaq_pkg.sv
// ----------------------------------------------------------------------------
// eaq_pkg: shared types, constants and tables
// Holds the fixed-point formats, the arctangent table of the rotator chain
// and the stage record handed from cell to cell.
// ----------------------------------------------------------------------------
package eaq_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;
  localparam int Z_FRAC      = 29 + ANGLE_BITS;
  localparam int ZW          = ANGLE_BITS + 32;
  localparam int XW          = 33;

  localparam logic signed [31:0] PI_Q29       = 32'sd1686629713;
  localparam logic signed [XW-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  typedef logic signed [15:0]   sample_t;
  typedef logic signed [ZW-1:0] zang_t;
  typedef logic signed [XW-1:0] trig_t;

  // One rotator per angle, three angles travel together through the chain.
  typedef struct packed {
    trig_t [2:0] x;
    trig_t [2:0] y;
    zang_t [2:0] z;
  } rot_t;

  // Shift-and-subtract quotient, used only to build the constant table.
  function automatic logic [63:0] udiv_const(input logic [63:0] num,
                                             input int unsigned den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= 64'(den)) begin
        rem  = rem - 64'(den);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic zang_t atan_stage(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q61 >> (34 - ANGLE_BITS);
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = Z_FRAC - i * (2 * k + 1);
        if (e >= 0) begin
          term = udiv_const(64'd1 << e, 2 * k + 1);
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc[ZW-1:0];
  endfunction

  function automatic zang_t field_to_angle(input sample_t a);
    logic signed [ANGLE_BITS-1:0] s;
    if (ANGLE_BITS >= 16) s = ANGLE_BITS'(a) <<< (ANGLE_BITS - 16);
    else s = ANGLE_BITS'(a >>> (16 - ANGLE_BITS));
    return ZW'(s);
  endfunction

endpackage

FILE: rtl/core/eaq_stream_if.sv
// ----------------------------------------------------------------------------
// eaq_stream_if: valid/ready channel
// Carries one request of a generic payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface eaq_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/euler_angles_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion: ZYX Euler angles to unit quaternion
// A request passes through the entry register, 16 rotator cells and three
// product stages, in that order, before its result is shown.
// Throughput: one request per cycle, set by the pipelined rotator chain,
// while the output is not stalled. The whole pipeline advances together;
// it stalls only while the output register is full and not taken.
// Reset (asynchronous, active low) empties every stage; no payload is cleared.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion (
  input  logic clk_i,
  input  logic rst_ni,
  eaq_stream_if.sink   in_i,
  eaq_stream_if.source out_o
);
  import eaq_pkg::*;

  // Pipeline enable: move when the final stage is empty or being drained.
  logic en;
  rot_t rot   [TRIG_STAGES+1];
  logic valid [TRIG_STAGES+2];
  logic [63:0] quat;

  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Entry register converts angles into the rotator's start vectors.
  logic v0_q;
  rot_t r0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        r0_q.x[a] <= INV_GAIN_Q30;
        r0_q.y[a] <= '0;
      end
      r0_q.z[0] <= field_to_angle(in_i.data[15:0]) * PI_Q29;
      r0_q.z[1] <= field_to_angle(in_i.data[31:16]) * PI_Q29;
      r0_q.z[2] <= field_to_angle(in_i.data[47:32]) * PI_Q29;
    end
  end

  assign rot[0]   = r0_q;
  assign valid[0] = v0_q;

  // Chain of identical rotator cells, each one micro-rotation.
  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    localparam zang_t ATAN = atan_stage(g);
    eaq_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (5'(g)),
      .valid_i (valid[g]),
      .rot_i   (rot[g]),
      .atan_i  (ATAN),
      .valid_o (valid[g+1]),
      .rot_o   (rot[g+1])
    );
  end

  eaq_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid[TRIG_STAGES]),
    .rot_i   (rot[TRIG_STAGES]),
    .valid_o (valid[TRIG_STAGES+1]),
    .quat_o  (quat)
  );

  assign out_o.valid = valid[TRIG_STAGES+1];
  assign out_o.data  = quat;
endmodule

FILE: rtl/core/eaq_cordic_cell.sv
// ----------------------------------------------------------------------------
// eaq_cordic_cell: one rotator stage
// Performs one micro-rotation on all three angles and registers the result.
// ----------------------------------------------------------------------------
module eaq_cordic_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [4:0]      stage_i,
  input  logic            valid_i,
  input  eaq_pkg::rot_t   rot_i,
  input  eaq_pkg::zang_t  atan_i,
  output logic            valid_o,
  output eaq_pkg::rot_t   rot_o
);
  import eaq_pkg::*;

  rot_t rot_d;
  logic valid_q;
  rot_t rot_q;

  always_comb begin
    trig_t dx, dy;
    rot_d = rot_i;
    for (int a = 0; a < 3; a++) begin
      dx = rot_i.y[a] >>> stage_i;
      dy = rot_i.x[a] >>> stage_i;
      if (!rot_i.z[a][ZW-1]) begin
        rot_d.x[a] = rot_i.x[a] - dx;
        rot_d.y[a] = rot_i.y[a] + dy;
        rot_d.z[a] = rot_i.z[a] - atan_i;
      end else begin
        rot_d.x[a] = rot_i.x[a] + dx;
        rot_d.y[a] = rot_i.y[a] - dy;
        rot_d.z[a] = rot_i.z[a] + atan_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
endmodule

FILE: rtl/core/eaq_product.sv
// ----------------------------------------------------------------------------
// eaq_product: triple-product datapath
// Forms pair products, then the four sums of triple products, rounds to Q15.
// ----------------------------------------------------------------------------
module eaq_product (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  eaq_pkg::rot_t rot_i,
  output logic          valid_o,
  output logic [63:0]   quat_o
);
  import eaq_pkg::*;

  function automatic trig_t mul_q30(input trig_t a, input trig_t b);
    logic signed [2*XW-1:0] p;
    p = a * b + (66'sd1 <<< 29);
    return XW'(p >>> 30);
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [2*XW:0] v);
    logic signed [2*XW:0] r;
    r = (v + (67'sd1 <<< 44)) >>> 45;
    if (r > 67'sd32767) return 16'h7fff;
    if (r < -67'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  logic        v1_q, v2_q, v3_q;
  trig_t       sr_q, cr_q, cpcy_q, spsy_q, spcy_q, cpsy_q;
  logic signed [2*XW-1:0] p_q [8];
  logic [63:0] quat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q   <= rot_i.y[0];
      cr_q   <= rot_i.x[0];
      cpcy_q <= mul_q30(rot_i.x[1], rot_i.x[2]);
      spsy_q <= mul_q30(rot_i.y[1], rot_i.y[2]);
      spcy_q <= mul_q30(rot_i.y[1], rot_i.x[2]);
      cpsy_q <= mul_q30(rot_i.x[1], rot_i.y[2]);
      p_q[0] <= sr_q * cpcy_q;
      p_q[1] <= cr_q * spsy_q;
      p_q[2] <= cr_q * spcy_q;
      p_q[3] <= sr_q * cpsy_q;
      p_q[4] <= cr_q * cpsy_q;
      p_q[5] <= sr_q * spcy_q;
      p_q[6] <= cr_q * cpcy_q;
      p_q[7] <= sr_q * spsy_q;
      quat_q[15:0]  <= to_q15(67'(p_q[0]) - 67'(p_q[1]));
      quat_q[31:16] <= to_q15(67'(p_q[2]) + 67'(p_q[3]));
      quat_q[47:32] <= to_q15(67'(p_q[4]) - 67'(p_q[5]));
      quat_q[63:48] <= to_q15(67'(p_q[6]) + 67'(p_q[7]));
    end
  end

  assign valid_o = v3_q;
  assign quat_o  = quat_q;
endmodule

FILE: rtl/core/eaq_checker.sv
// ----------------------------------------------------------------------------
// eaq_checker: port-level checks
// Watches the top level's channels for stall behavior and request flow.
// ----------------------------------------------------------------------------
module eaq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken during stall");
endmodule

bind euler_angles_to_quaternion eaq_checker u_eaq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for euler_angles_to_quaternion
// Drives roll/pitch/yaw requests through the valid/ready channel with random
// idle bursts on both sides. A bit-exact CORDIC model predicts each
// quaternion, and every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import eaq_pkg::*;

  // Request payload: the three attitude angles, roll in the low bits.
  typedef struct packed {
    sample_t yaw;
    sample_t pitch;
    sample_t roll;
  } angles_t;

  // Result payload: quaternion components, x in the low bits.
  typedef struct packed {
    sample_t qw;
    sample_t qz;
    sample_t qy;
    sample_t qx;
  } quat_t;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES    = 40;

  logic clk_i;
  logic rst_ni;

  eaq_stream_if #(.payload_t(angles_t)) in_if ();
  eaq_stream_if #(.payload_t(quat_t))   out_if ();

  euler_angles_to_quaternion dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  quat_t expected_quats[$];
  int    mismatches;
  bit    quiet;         // When set, neither side inserts idle cycles.
  int    stall_left;
  int    idle_cycles;
  longint arctan_q45[TRIG_STAGES];

  // --------------------------------------------------------------------------
  // Quaternion predictor.
  // The rotator works on the half angle in Q45 radians and produces sine and
  // cosine in Q30. Shifts are arithmetic, so they floor like the hardware.
  // --------------------------------------------------------------------------
  function automatic void build_arctan_table();
    longint acc;
    longint term;
    int e;
    arctan_q45[0] = longint'(PI_Q61 >> (34 - ANGLE_BITS));
    for (int i = 1; i < TRIG_STAGES; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = Z_FRAC - i * (2 * k + 1);
        if (e >= 0) begin
          term = longint'((64'd1 << e) / (2 * k + 1));
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      arctan_q45[i] = acc;
    end
  endfunction

  function automatic void half_angle_sincos(input sample_t ang, output longint s,
                                            output longint c);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    // ANGLE_BITS equals the field width, so the angle word is the field itself.
    z = longint'(ang) * 64'sd1686629713;
    for (int i = 0; i < TRIG_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      // A zero residual angle rotates in the positive direction.
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q45[i];
      end else begin
        x += dx; y -= dy; z += arctan_q45[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint mul_round_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic sample_t q60_to_q15_sat(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 44)) >>> 45;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return sample_t'(r);
  endfunction

  function automatic quat_t predict_quat(input angles_t a);
    longint sr, cr, sp, cp, sy, cy;
    longint cpcy, spsy, spcy, cpsy;
    quat_t q;
    half_angle_sincos(a.roll, sr, cr);
    half_angle_sincos(a.pitch, sp, cp);
    half_angle_sincos(a.yaw, sy, cy);
    cpcy = mul_round_q30(cp, cy);
    spsy = mul_round_q30(sp, sy);
    spcy = mul_round_q30(sp, cy);
    cpsy = mul_round_q30(cp, sy);
    q.qx = q60_to_q15_sat(sr * cpcy - cr * spsy);
    q.qy = q60_to_q15_sat(cr * spcy + sr * cpsy);
    q.qz = q60_to_q15_sat(cr * cpsy - sr * spcy);
    q.qw = q60_to_q15_sat(cr * cpcy + sr * spsy);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and the result side.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The sink stalls in random bursts of random length unless quiet is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 15);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Every accepted result is compared against the oldest prediction.
  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected result %h with nothing outstanding", out_if.data);
        mismatches++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_if.data.qx !== exp_q.qx) begin
          $error("quat_x: expected %0d, got %0d", exp_q.qx, out_if.data.qx);
          mismatches++;
        end
        if (out_if.data.qy !== exp_q.qy) begin
          $error("quat_y: expected %0d, got %0d", exp_q.qy, out_if.data.qy);
          mismatches++;
        end
        if (out_if.data.qz !== exp_q.qz) begin
          $error("quat_z: expected %0d, got %0d", exp_q.qz, out_if.data.qz);
          mismatches++;
        end
        if (out_if.data.qw !== exp_q.qw) begin
          $error("quat_w: expected %0d, got %0d", exp_q.qw, out_if.data.qw);
          mismatches++;
        end
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Each call holds valid until the request is accepted; the
  // prediction is queued at the accepting edge. Between requests the source
  // may drop valid for a random burst.
  // --------------------------------------------------------------------------
  task automatic send_angles(input angles_t a);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= a;
    do @(posedge clk_i); while (!in_if.ready);
    expected_quats = {expected_quats, predict_quat(a)};
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
  endtask

  function automatic angles_t random_angles();
    angles_t a;
    a = angles_t'(48'({$urandom, $urandom}));
    // Some samples stay near level attitude, where real sensors spend time.
    if ($urandom_range(0, 3) == 0) begin
      a.roll  = sample_t'($signed($urandom_range(0, 2047)) - 1024);
      a.pitch = sample_t'($signed($urandom_range(0, 2047)) - 1024);
    end
    return a;
  endfunction

  // Field extremes: each angle at -180, just under +180, zero, and -1 LSB.
  task automatic test_field_extremes();
    sample_t corners[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    foreach (corners[i]) begin
      send_angles('{roll: corners[i], pitch: 16'sh0, yaw: 16'sh0});
      send_angles('{roll: 16'sh0, pitch: corners[i], yaw: 16'sh0});
      send_angles('{roll: 16'sh0, pitch: 16'sh0, yaw: corners[i]});
    end
    send_angles('{roll: 16'sh8000, pitch: 16'sh8000, yaw: 16'sh8000});
    send_angles('{roll: 16'sh7fff, pitch: 16'sh7fff, yaw: 16'sh7fff});
  endtask

  // Components at or near +/-1.0 exercise the saturation of the result.
  task automatic test_saturation();
    send_angles('{roll: 16'sh0, pitch: 16'sh0, yaw: 16'sh0});
    send_angles('{roll: 16'sh8000, pitch: 16'sh0, yaw: 16'sh0});
    send_angles('{roll: 16'sh0, pitch: 16'sh8000, yaw: 16'sh0});
    send_angles('{roll: 16'sh0, pitch: 16'sh0, yaw: 16'sh8000});
    send_angles('{roll: 16'sh4000, pitch: 16'shc000, yaw: 16'sh4000});
    send_angles('{roll: 16'shaaaa, pitch: 16'sh5555, yaw: 16'shaaaa});
  endtask

  // The source stops until the pipeline has drained completely, then resumes.
  task automatic test_drain_pause();
    repeat (30) send_angles(random_angles());
    wait_for_results();
    repeat (30) send_angles(random_angles());
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_angles(random_angles());
  endtask

  initial begin
    mismatches    = 0;
    quiet         = 1'b0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    build_arctan_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_saturation();
    test_drain_pause();
    test_random_stream(1500);
    // Last stretch runs back to back on both sides.
    quiet = 1'b1;
    test_random_stream(250);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_quats.size() != 0) begin
      $error("%0d results never arrived", expected_quats.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
